### rtl/kct_pkg.sv
// Shared constants, codes and types of the key count table.
package kct_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W   = $clog2(CAPACITY + 1);

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 31;
    localparam int STATUS_W = 2;

    localparam int S_FIELDS_W = ACTION_W + KEY_W + KEY_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = COUNT_W + STATUS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [ACTION_W-1:0] ACT_ADD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GET = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SET = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [COUNT_W-1:0] key;
        logic [COUNT_W-1:0] count;
    } entry_t;

endpackage

### rtl/kct_entry_ram.sv
// Synchronous entry memory with one write port and one registered read port.
module kct_entry_ram (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [kct_pkg::IDX_W-1:0] waddr,
    input  kct_pkg::entry_t           wdata,
    input  logic [kct_pkg::IDX_W-1:0] raddr,
    output kct_pkg::entry_t           rdata
);

    kct_pkg::entry_t mem [kct_pkg::CAPACITY];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/key_count_table_unit.sv
// Top level of the key count table: control sequencer, fill count and output register.
//
// The block keeps up to 64 distinct non-negative keys, each with a count that
// saturates at 2^31-1. Each input item on the s_ channel carries an action
// (add one, get count, set count), a key and a new count; each item produces
// exactly one result item on the m_ channel with the count and a status.
// Entries are filled in order from index 0 and are never removed, so a fill
// count marks which entries hold keys.
// A valid item scans the occupied entries through the registered read port of the
// entry memory, one entry per cycle, and stops at the first match. It then
// passes through the UPDATE state and the DONE state, which loads the output register;
// a rejected operand goes straight to DONE. The next item is accepted once the block
// is back in IDLE after that result is loaded, and the block works on one item at a time.
// A new item is accepted while the previous result still waits in the output
// register; when the receiver stalls, the block holds a finished result
// internally and stops accepting until the output register frees up.
// Reset empties the table at once and clears both channels.
module key_count_table_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // action [1:0], key [33:2], new_count [65:34], zero fill above
    input  logic [kct_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // count_out [30:0], status [32:31], zero fill above
    output logic [kct_pkg::M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [3:0] {
        IDLE   = 4'b0001,
        SCAN   = 4'b0010,
        UPDATE = 4'b0100,
        DONE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [kct_pkg::ACTION_W-1:0] action_reg, action_next;
    logic [kct_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [kct_pkg::KEY_W-1:0]    ncount_reg, ncount_next;

    logic [kct_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [kct_pkg::FILL_W-1:0]   issue_idx_reg, issue_idx_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic [kct_pkg::IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                         hit_reg, hit_next;
    logic [kct_pkg::IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [kct_pkg::COUNT_W-1:0]  hit_count_reg, hit_count_next;

    logic [kct_pkg::COUNT_W-1:0]  res_count_reg, res_count_next;
    logic [kct_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [kct_pkg::COUNT_W-1:0]  m_count_reg, m_count_next;
    logic [kct_pkg::STATUS_W-1:0] m_status_reg, m_status_next;

    logic                         ram_we;
    logic [kct_pkg::IDX_W-1:0]    ram_waddr;
    kct_pkg::entry_t              ram_wdata;
    kct_pkg::entry_t              ram_rdata;

    logic                         s_fire;
    logic                         in_reject;
    logic                         issue_fire;
    logic                         rd_hit;
    logic                         out_free;
    logic [kct_pkg::ACTION_W-1:0] in_action;
    logic [kct_pkg::KEY_W-1:0]    in_key;
    logic [kct_pkg::KEY_W-1:0]    in_ncount;
    logic [kct_pkg::COUNT_W-1:0]  add_count;

    kct_entry_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_idx_reg[kct_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign in_action = s_tdata[kct_pkg::ACTION_W-1:0];
    assign in_key    = s_tdata[kct_pkg::ACTION_W +: kct_pkg::KEY_W];
    assign in_ncount = s_tdata[kct_pkg::ACTION_W + kct_pkg::KEY_W +: kct_pkg::KEY_W];

    assign s_tready = (state_reg == IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign in_reject = (in_action != kct_pkg::ACT_ADD && in_action != kct_pkg::ACT_GET &&
                        in_action != kct_pkg::ACT_SET) || in_key[kct_pkg::KEY_W-1] ||
                       (in_action == kct_pkg::ACT_SET && in_ncount[kct_pkg::KEY_W-1]);

    assign issue_fire = (state_reg == SCAN) && !rd_hit && (issue_idx_reg != fill_reg);
    assign rd_hit     = rd_valid_reg && (ram_rdata.key == key_reg[kct_pkg::COUNT_W-1:0]);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign add_count  = (hit_count_reg == kct_pkg::COUNT_MAX) ? hit_count_reg
                                                              : hit_count_reg + 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(kct_pkg::M_TDATA_W - kct_pkg::M_FIELDS_W){1'b0}},
                       m_status_reg, m_count_reg};

    always_comb begin
        state_next      = state_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        ncount_next     = ncount_reg;
        fill_next       = fill_reg;
        issue_idx_next  = issue_idx_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = issue_idx_reg[kct_pkg::IDX_W-1:0];
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_count_next  = hit_count_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_count_next    = m_count_reg;
        m_status_next   = m_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata.key   = key_reg[kct_pkg::COUNT_W-1:0];
        ram_wdata.count = add_count;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            IDLE: begin
                if (s_fire) begin
                    action_next    = in_action;
                    key_next       = in_key;
                    ncount_next    = in_ncount;
                    issue_idx_next = '0;
                    if (in_reject) begin
                        res_count_next  = '0;
                        res_status_next = kct_pkg::ST_REJECT;
                        state_next      = DONE;
                    end else begin
                        state_next = SCAN;
                    end
                end
            end
            SCAN: begin
                rd_valid_next = issue_fire;
                if (issue_fire) begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                if (rd_hit) begin
                    hit_next       = 1'b1;
                    hit_idx_next   = rd_idx_reg;
                    hit_count_next = ram_rdata.count;
                    state_next     = UPDATE;
                end else if (!rd_valid_reg && issue_idx_reg == fill_reg) begin
                    hit_next   = 1'b0;
                    state_next = UPDATE;
                end
            end
            UPDATE: begin
                res_status_next = kct_pkg::ST_OK;
                state_next      = DONE;
                if (action_reg == kct_pkg::ACT_GET) begin
                    res_count_next = hit_reg ? hit_count_reg : '0;
                end else if (hit_reg) begin
                    ram_we = 1'b1;
                    if (action_reg == kct_pkg::ACT_SET) begin
                        ram_wdata.count = ncount_reg[kct_pkg::COUNT_W-1:0];
                    end
                    res_count_next = ram_wdata.count;
                end else if (fill_reg == kct_pkg::FILL_W'(kct_pkg::CAPACITY)) begin
                    res_count_next  = '0;
                    res_status_next = kct_pkg::ST_FULL;
                end else begin
                    ram_we          = 1'b1;
                    ram_waddr       = fill_reg[kct_pkg::IDX_W-1:0];
                    ram_wdata.count = (action_reg == kct_pkg::ACT_ADD)
                                      ? kct_pkg::COUNT_W'(1)
                                      : ncount_reg[kct_pkg::COUNT_W-1:0];
                    res_count_next  = ram_wdata.count;
                    fill_next       = fill_reg + 1'b1;
                end
            end
            DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_count_next  = res_count_reg;
                    m_status_next = res_status_reg;
                    state_next    = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            rd_valid_reg <= rd_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg     <= action_next;
        key_reg        <= key_next;
        ncount_reg     <= ncount_next;
        issue_idx_reg  <= issue_idx_next;
        rd_idx_reg     <= rd_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_count_reg  <= hit_count_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        m_count_reg    <= m_count_next;
        m_status_reg   <= m_status_next;
    end

endmodule

### sim/tb_key_count_table_unit.sv
// Self-checking testbench for the key count table: directed cases, random traffic, full table.
`timescale 1ns / 100ps

module tb_key_count_table_unit;

    localparam logic [kct_pkg::ACTION_W-1:0] ACT_RESERVED = 2'd3;
    localparam int CLK_HALF = 2;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 80;
    localparam int IDLE_PCT = 11;
    localparam int POOL_SIZE = 44;
    localparam int POOL_ITEMS = 620;
    localparam int FULL_ITEMS = 560;

    typedef struct packed {
        logic [kct_pkg::COUNT_W-1:0]  count;
        logic [kct_pkg::STATUS_W-1:0] status;
    } table_result_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [kct_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [kct_pkg::M_TDATA_W-1:0] m_tdata;

    logic                        tbl_valid [kct_pkg::CAPACITY];
    logic [kct_pkg::COUNT_W-1:0] tbl_key   [kct_pkg::CAPACITY];
    logic [kct_pkg::COUNT_W-1:0] tbl_count [kct_pkg::CAPACITY];
    int                          tbl_fill;
    logic [kct_pkg::COUNT_W-1:0] key_pool  [POOL_SIZE];

    table_result_t pending_results[$];
    int            mismatch_count;
    int            cycle_count;
    bit            no_idle;

    key_count_table_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_key_count_table_unit NOT OK");
            $finish;
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Applies one operation to the table copy and returns the result it should produce.
    function automatic table_result_t predict_table_op(
        input logic [kct_pkg::ACTION_W-1:0] act,
        input logic [kct_pkg::KEY_W-1:0] key,
        input logic [kct_pkg::KEY_W-1:0] cnt);
        table_result_t res;
        int hit;
        int slot;
        res.count  = '0;
        res.status = kct_pkg::ST_OK;
        hit  = -1;
        slot = -1;
        if (act == ACT_RESERVED || key[kct_pkg::KEY_W-1] ||
            (act == kct_pkg::ACT_SET && cnt[kct_pkg::KEY_W-1])) begin
            res.status = kct_pkg::ST_REJECT;
            return res;
        end
        for (int i = 0; i < kct_pkg::CAPACITY; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == key[kct_pkg::COUNT_W-1:0])
                hit = i;
            if (slot < 0 && !tbl_valid[i])
                slot = i;
        end
        if (act == kct_pkg::ACT_GET) begin
            if (hit >= 0)
                res.count = tbl_count[hit];
        end else if (hit >= 0) begin
            if (act == kct_pkg::ACT_ADD) begin
                if (tbl_count[hit] != kct_pkg::COUNT_MAX)
                    tbl_count[hit] = tbl_count[hit] + 1'b1;
            end else begin
                tbl_count[hit] = cnt[kct_pkg::COUNT_W-1:0];
            end
            res.count = tbl_count[hit];
        end else if (slot < 0) begin
            res.status = kct_pkg::ST_FULL;
        end else begin
            tbl_valid[slot] = 1'b1;
            tbl_key[slot]   = key[kct_pkg::COUNT_W-1:0];
            tbl_count[slot] = (act == kct_pkg::ACT_ADD) ? kct_pkg::COUNT_W'(1)
                                                        : cnt[kct_pkg::COUNT_W-1:0];
            tbl_fill++;
            res.count = tbl_count[slot];
        end
        return res;
    endfunction

    task automatic send_item(input logic [kct_pkg::ACTION_W-1:0] act,
                             input logic [kct_pkg::KEY_W-1:0] key,
                             input logic [kct_pkg::KEY_W-1:0] cnt);
        @(negedge aclk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = '0;
        s_tdata[kct_pkg::ACTION_W-1:0]                             = act;
        s_tdata[kct_pkg::ACTION_W +: kct_pkg::KEY_W]                  = key;
        s_tdata[kct_pkg::ACTION_W + kct_pkg::KEY_W +: kct_pkg::KEY_W] = cnt;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_results.push_back(predict_table_op(act, key, cnt));
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    function automatic logic [kct_pkg::KEY_W-1:0] random_count();
        case ($urandom_range(0, 9))
            0: return {1'b0, kct_pkg::COUNT_MAX};
            1: return {1'b0, kct_pkg::COUNT_MAX - 1'b1};
            2: return '0;
            3: return kct_pkg::KEY_W'($urandom_range(0, 10));
            default: return {1'b0, kct_pkg::COUNT_W'($urandom)};
        endcase
    endfunction

    // Mostly well-formed operations on pooled or fresh random keys; the rest are rejected operands.
    task automatic send_random_op(input int fresh_pct, input bit fresh_get_only);
        logic [kct_pkg::ACTION_W-1:0] act;
        logic [kct_pkg::KEY_W-1:0]    key;
        logic [kct_pkg::KEY_W-1:0]    cnt;
        act = kct_pkg::ACTION_W'($urandom_range(0, 2));
        key = {1'b0, key_pool[$urandom_range(0, POOL_SIZE - 1)]};
        cnt = (act == kct_pkg::ACT_SET) ? random_count() : kct_pkg::KEY_W'($urandom);
        if ($urandom_range(0, 99) < fresh_pct) begin
            key = {1'b0, kct_pkg::COUNT_W'($urandom)};
            if (fresh_get_only)
                act = kct_pkg::ACT_GET;
        end
        if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 2))
                0: key = kct_pkg::KEY_W'($urandom) | 32'h8000_0000;
                1: begin
                    act = kct_pkg::ACT_SET;
                    cnt = kct_pkg::KEY_W'($urandom) | 32'h8000_0000;
                end
                default: act = ACT_RESERVED;
            endcase
        end
        send_item(act, key, cnt);
    endtask

    task automatic test_directed();
        send_item(kct_pkg::ACT_GET, 32'd0, 32'd0);
        send_item(kct_pkg::ACT_ADD, 32'd0, 32'hFFFF_FFFF);
        send_item(kct_pkg::ACT_ADD, 32'd0, 32'd0);
        send_item(kct_pkg::ACT_GET, 32'd0, 32'h8000_0000);
        send_item(kct_pkg::ACT_SET, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(kct_pkg::ACT_ADD, 32'h7FFF_FFFF, 32'd0);
        send_item(kct_pkg::ACT_GET, 32'h7FFF_FFFF, 32'd0);
        send_item(kct_pkg::ACT_SET, 32'd5, 32'd0);
        send_item(kct_pkg::ACT_ADD, 32'd5, 32'd0);
        send_item(kct_pkg::ACT_SET, 32'd0, 32'd0);
        send_item(kct_pkg::ACT_SET, 32'd0, 32'h7FFF_FFFE);
        send_item(kct_pkg::ACT_ADD, 32'd0, 32'd0);
        send_item(kct_pkg::ACT_ADD, 32'd0, 32'd0);
        send_item(kct_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'd1);
        send_item(kct_pkg::ACT_GET, 32'h8000_0000, 32'd0);
        send_item(kct_pkg::ACT_SET, 32'h8000_0000, 32'd5);
        send_item(kct_pkg::ACT_SET, 32'd7, 32'hFFFF_FFFF);
        send_item(kct_pkg::ACT_SET, 32'd7, 32'h8000_0000);
        send_item(kct_pkg::ACT_GET, 32'd7, 32'd0);
        send_item(ACT_RESERVED, 32'd0, 32'd0);
        send_item(ACT_RESERVED, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(kct_pkg::ACT_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
        send_item(kct_pkg::ACT_SET, 32'h2AAA_AAAA, 32'h5555_5555);
    endtask

    task automatic test_random_pool();
        key_pool[0] = '0;
        key_pool[1] = kct_pkg::COUNT_MAX;
        key_pool[2] = kct_pkg::COUNT_W'(5);
        key_pool[3] = kct_pkg::COUNT_W'(32'h5555_5555);
        key_pool[4] = kct_pkg::COUNT_W'(32'h2AAA_AAAA);
        for (int i = 5; i < POOL_SIZE; i++)
            key_pool[i] = kct_pkg::COUNT_W'($urandom);
        for (int n = 0; n < POOL_ITEMS; n++) begin
            if (n == POOL_ITEMS / 2)
                wait_results_drained();
            send_random_op(8, 1'b1);
        end
    endtask

    // Back-to-back inserts of new keys until the table is full, then a few misses.
    task automatic test_fill_table();
        logic [kct_pkg::ACTION_W-1:0] act;
        no_idle = 1'b1;
        while (tbl_fill < kct_pkg::CAPACITY) begin
            act = $urandom_range(0, 1) ? kct_pkg::ACT_ADD : kct_pkg::ACT_SET;
            send_item(act, {1'b0, kct_pkg::COUNT_W'($urandom)}, random_count());
        end
        send_item(kct_pkg::ACT_ADD, {1'b0, kct_pkg::COUNT_W'($urandom)}, 32'd0);
        send_item(kct_pkg::ACT_SET, {1'b0, kct_pkg::COUNT_W'($urandom)}, 32'd9);
        send_item(kct_pkg::ACT_GET, {1'b0, kct_pkg::COUNT_W'($urandom)}, 32'd0);
        no_idle = 1'b0;
    endtask

    task automatic test_random_full();
        for (int n = 0; n < FULL_ITEMS; n++)
            send_random_op(25, 1'b0);
    endtask

    always @(posedge aclk) begin
        table_result_t want;
        logic [kct_pkg::COUNT_W-1:0]  got_count;
        logic [kct_pkg::STATUS_W-1:0] got_status;
        if (aresetn && m_tvalid && m_tready) begin
            got_count  = m_tdata[kct_pkg::COUNT_W-1:0];
            got_status = m_tdata[kct_pkg::COUNT_W +: kct_pkg::STATUS_W];
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: count %0d status %0d", got_count, got_status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got_count !== want.count || got_status !== want.status) begin
                    if (mismatch_count < 10)
                        $display("result mismatch: expected count %0d status %0d, got %0d %0d",
                                 want.count, want.status, got_count, got_status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        no_idle  = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        tbl_fill       = 0;
        for (int i = 0; i < kct_pkg::CAPACITY; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_count[i] = '0;
        end
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_pool();
        test_fill_table();
        test_random_full();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_key_count_table_unit OK");
        end else begin
            $display("tb_key_count_table_unit NOT OK");
        end
        $finish;
    end

endmodule
